FILE: sv/nfd_pkg.sv
`timescale 1ns / 1ps

package nfd_pkg;

    // Longest frame that the buffer is sized for; longer heater frames are refused.
    localparam int unsigned MAX_FRAME = 32;

    // Byte counter width and its saturation value.
    localparam int unsigned CNT_W     = 6;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Depth of the queue between the frame checker and the record update.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Framing bytes.
    localparam logic [7:0] AC_SYNC     = 8'h5A;
    localparam logic [7:0] AC_CR       = 8'h0D;
    localparam logic [7:0] AC_LF       = 8'h0A;
    localparam logic [7:0] HT_SYNC     = 8'h55;
    localparam logic [7:0] HT_IDLE_TAG = 8'h0F;

    // Air conditioner command codes.
    localparam logic [7:0] CMD_POWER   = 8'h01;
    localparam logic [7:0] CMD_MODE    = 8'h02;
    localparam logic [7:0] CMD_TARGET  = 8'h03;
    localparam logic [7:0] CMD_FAN     = 8'h04;
    localparam logic [7:0] CMD_CURRENT = 8'h07;
    localparam logic [7:0] CMD_SWING   = 8'h10;
    localparam logic [7:0] CMD_FAULT   = 8'h0B;

    // Data codes that switch a flag on.
    localparam logic [7:0] POWER_ON_CODE  = 8'h02;
    localparam logic [7:0] SWING_ON_CODE  = 8'h01;
    localparam logic [7:0] MANUAL_CODE    = 8'h01;

    // Ambient reading limit and offset in the long heater frame.
    localparam logic [15:0] AMB_LIMIT  = 16'd700;
    localparam logic [15:0] AMB_OFFSET = 16'd60;

    // Action picked by the frame checker for the record update.
    typedef enum logic [3:0] {
        ACT_REJECT,
        ACT_NONE,
        ACT_AC_POWER,
        ACT_AC_MODE,
        ACT_AC_TARGET,
        ACT_AC_FAN,
        ACT_AC_CURRENT,
        ACT_AC_SWING,
        ACT_AC_FAULT,
        ACT_HT_SHORT,
        ACT_HT_LONG
    } act_t;

    typedef enum logic [1:0] {
        TEMP_NONE,
        TEMP_CELSIUS,
        TEMP_FAHR
    } temp_kind_t;

    // Temperature request: whole Celsius degrees or Fahrenheit degrees.
    typedef struct packed {
        temp_kind_t         kind;
        logic signed [10:0] value;
    } temp_req_t;

    // One classified frame, as handed from the checker to the updater.
    typedef struct packed {
        act_t        act;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic [2:0]  fan;
        logic        flag;
        temp_req_t   temp;
        logic [15:0] alt;
    } desc_t;

    // Kept device record.
    typedef struct packed {
        logic               power;
        logic [7:0]         mode;
        logic signed [13:0] target;
        logic signed [13:0] current;
        logic [2:0]         fan;
        logic               swing;
        logic [7:0]         fault;
        logic               manual;
        logic [7:0]         status;
        logic [15:0]        alt;
        logic               alt_known;
    } rec_t;

endpackage

FILE: sv/nfd_front.sv
`timescale 1ns / 1ps

module nfd_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tlast,
    input  logic          s_tuser,
    output logic          push,
    output nfd_pkg::desc_t push_desc,
    input  logic          q_full
);
    import nfd_pkg::*;

    // Only the frame positions that any check reads are kept.
    localparam int unsigned NCAP = 16;
    localparam int unsigned CAP_POS [NCAP] = '{0, 1, 4, 5, 7, 8, 12, 13, 14, 15,
                                               16, 17, 18, 19, 24, 25};
    localparam int unsigned P0  = 0;
    localparam int unsigned P1  = 1;
    localparam int unsigned P4  = 2;
    localparam int unsigned P5  = 3;
    localparam int unsigned P7  = 4;
    localparam int unsigned P8  = 5;
    localparam int unsigned P12 = 6;
    localparam int unsigned P13 = 7;
    localparam int unsigned P14 = 8;
    localparam int unsigned P15 = 9;
    localparam int unsigned P16 = 10;
    localparam int unsigned P17 = 11;
    localparam int unsigned P18 = 12;
    localparam int unsigned P19 = 13;
    localparam int unsigned P24 = 14;
    localparam int unsigned P25 = 15;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       cap_reg [NCAP];
    logic [7:0]       fb      [NCAP];
    logic [CNT_W-1:0] len;
    logic             take;
    logic [15:0]      amb;
    desc_t            desc;

    function automatic logic [2:0] clamp_fan(input logic [7:0] raw);
        logic [2:0] res;
        if (raw == 8'd0) begin
            res = 3'd1;
        end else if (raw > 8'd5) begin
            res = 3'd5;
        end else begin
            res = raw[2:0];
        end
        return res;
    endfunction

    function automatic temp_req_t decode_temp(input logic [7:0] raw, input logic [7:0] lo,
                                              input logic [7:0] hi, input logic [7:0] flo);
        temp_req_t res;
        res.value = 11'({3'b000, raw});
        if (raw >= lo && raw <= hi) begin
            res.kind = TEMP_CELSIUS;
        end else if (raw >= flo && raw <= 8'd99) begin
            res.kind = TEMP_FAHR;
        end else begin
            res.kind = TEMP_NONE;
        end
        return res;
    endfunction

    assign s_tready = ~q_full;
    assign take     = s_tvalid & s_tready;
    assign len      = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign cnt_next = s_tlast ? '0 : len;

    // The byte now arriving stands in for its own position.
    always_comb begin
        for (int i = 0; i < NCAP; i++) begin
            fb[i] = (cnt_reg == CNT_W'(CAP_POS[i])) ? s_tdata : cap_reg[i];
        end
    end

    assign amb = {fb[P18], fb[P19]};

    always_comb begin
        desc        = '0;
        desc.act    = ACT_REJECT;
        desc.temp   = '{kind: TEMP_NONE, value: '0};
        if (!s_tuser) begin
            desc.byte_a = fb[P5];
            if (len == CNT_W'(9) && fb[P0] == AC_SYNC && fb[P1] == AC_SYNC &&
                fb[P7] == AC_CR && fb[P8] == AC_LF) begin
                desc.fan  = clamp_fan(fb[P5]);
                desc.temp = decode_temp(fb[P5], 8'd16, 8'd30, 8'd60);
                unique case (fb[P4])
                    CMD_POWER: begin
                        desc.act  = ACT_AC_POWER;
                        desc.flag = (fb[P5] == POWER_ON_CODE);
                    end
                    CMD_MODE:    desc.act = ACT_AC_MODE;
                    CMD_TARGET:  desc.act = ACT_AC_TARGET;
                    CMD_FAN:     desc.act = ACT_AC_FAN;
                    CMD_CURRENT: desc.act = ACT_AC_CURRENT;
                    CMD_SWING: begin
                        desc.act  = ACT_AC_SWING;
                        desc.flag = (fb[P5] == SWING_ON_CODE);
                    end
                    CMD_FAULT:   desc.act = ACT_AC_FAULT;
                    default:     desc.act = ACT_REJECT;
                endcase
            end
        end else begin
            desc.byte_a = fb[P13];
            if (len >= CNT_W'(14) && {1'b0, len} <= (CNT_W + 1)'(MAX_FRAME) &&
                fb[P0] == HT_SYNC) begin
                if (len == CNT_W'(22)) begin
                    desc.act    = ACT_HT_SHORT;
                    desc.flag   = (fb[P14] == MANUAL_CODE);
                    desc.fan    = clamp_fan(fb[P15]);
                    desc.temp   = decode_temp(fb[P16], 8'd4, 8'd38, 8'd40);
                    desc.byte_b = fb[P17];
                end else if (len == CNT_W'(28)) begin
                    desc.act        = ACT_HT_LONG;
                    desc.alt        = {fb[P24], fb[P25]};
                    desc.temp.value = 11'(amb - AMB_OFFSET);
                    desc.temp.kind  = (amb <= AMB_LIMIT) ? TEMP_FAHR : TEMP_NONE;
                end else if ((len == CNT_W'(20) && fb[P12] == HT_IDLE_TAG) ||
                             len == CNT_W'(16) || len == CNT_W'(24)) begin
                    desc.act = ACT_NONE;
                end
            end
        end
    end

    assign push      = take & s_tlast;
    assign push_desc = desc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (take) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NCAP; i++) begin
            if (take && cnt_reg == CNT_W'(CAP_POS[i])) begin
                cap_reg[i] <= s_tdata;
            end
        end
    end

endmodule

FILE: sv/nfd_queue.sv
`timescale 1ns / 1ps

module nfd_queue #(
    parameter int unsigned DEPTH = nfd_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  nfd_pkg::desc_t push_desc,
    output logic           full,
    output logic           valid,
    output nfd_pkg::desc_t head,
    input  logic           pop
);
    import nfd_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    desc_t          mem_reg [DEPTH];
    logic [PW-1:0]  wr_reg, wr_next;
    logic [PW-1:0]  rd_reg, rd_next;
    logic [CW-1:0]  fill_reg, fill_next;
    logic           do_push, do_pop;

    assign full    = (fill_reg == CW'(DEPTH));
    assign valid   = (fill_reg != '0);
    assign head    = mem_reg[rd_reg];
    assign do_push = push & ~full;
    assign do_pop  = pop & valid;

    always_comb begin
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        fill_next = fill_reg;
        if (do_push) begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end else begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_desc;
        end
    end

endmodule

FILE: sv/nfd_back.sv
`timescale 1ns / 1ps

module nfd_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  nfd_pkg::desc_t q_desc,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [79:0]    m_tdata
);
    import nfd_pkg::*;

    // (x + 4) / 9 as a multiply by a rounded-up reciprocal; exact for x below 2^16.
    localparam int unsigned RECIP_SHIFT = 19;
    localparam logic [33:0] RECIP = 34'(((1 << RECIP_SHIFT) + 8) / 9);

    rec_t               rec_reg, rec_next;
    rec_t               out_reg;
    logic               acc_reg, acc_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [11:0] diff;
    logic               neg;
    logic [9:0]         mag;
    logic [16:0]        scaled;
    logic [33:0]        prod;
    logic [13:0]        quot;
    logic signed [13:0] temp;
    logic               temp_ok;

    // Temperature to 1/16 degree Celsius: Celsius times 16, Fahrenheit as (F - 32) * 80 / 9, rounded to nearest.
    always_comb begin
        diff   = 12'(q_desc.temp.value) - 12'sd32;
        neg    = diff[11];
        mag    = neg ? 10'(-diff) : 10'(diff);
        scaled = {1'b0, mag, 6'b0} + {3'b0, mag, 4'b0} + 17'd4;
        prod   = 34'(scaled) * RECIP;
        quot   = prod[RECIP_SHIFT +: 14];
        unique case (q_desc.temp.kind)
            TEMP_CELSIUS: temp = 14'(q_desc.temp.value) <<< 4;
            TEMP_FAHR:    temp = neg ? -$signed(quot) : $signed(quot);
            default:      temp = '0;
        endcase
        temp_ok = (q_desc.temp.kind != TEMP_NONE);
    end

    assign q_pop = q_valid & (~out_valid_reg | m_tready);

    always_comb begin
        rec_next = rec_reg;
        acc_next = 1'b1;
        unique case (q_desc.act)
            ACT_REJECT:   acc_next = 1'b0;
            ACT_NONE:     acc_next = 1'b1;
            ACT_AC_POWER: rec_next.power = q_desc.flag;
            ACT_AC_MODE:  rec_next.mode  = q_desc.byte_a;
            ACT_AC_TARGET: begin
                if (temp_ok) begin
                    rec_next.target = temp;
                end
            end
            ACT_AC_FAN:   rec_next.fan = q_desc.fan;
            ACT_AC_CURRENT: begin
                if (temp_ok) begin
                    rec_next.current = temp;
                end
            end
            ACT_AC_SWING: rec_next.swing = q_desc.flag;
            ACT_AC_FAULT: rec_next.fault = q_desc.byte_a;
            ACT_HT_SHORT: begin
                rec_next.fault  = q_desc.byte_a;
                rec_next.manual = q_desc.flag;
                rec_next.fan    = q_desc.fan;
                if (temp_ok) begin
                    rec_next.target = temp;
                end
                rec_next.status = q_desc.byte_b;
                rec_next.power  = (q_desc.byte_b != 8'd0);
            end
            ACT_HT_LONG: begin
                rec_next.fault = q_desc.byte_a;
                if (temp_ok) begin
                    rec_next.current = temp;
                end
                rec_next.alt       = q_desc.alt;
                rec_next.alt_known = 1'b1;
            end
            default:      acc_next = 1'b0;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (q_pop) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                rec_reg <= rec_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= rec_next;
            acc_reg <= acc_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg.alt_known, out_reg.alt, out_reg.status,
                       out_reg.manual, out_reg.fault, out_reg.swing, out_reg.fan,
                       out_reg.current, out_reg.target, out_reg.mode, out_reg.power,
                       acc_reg};

endmodule

FILE: sv/notification_frame_decoder_unit.sv
`timescale 1ns / 1ps

// Notification frame decoder.
// The slave channel takes one frame byte per beat: s_tdata is the byte, s_tlast
// marks the final byte of a frame and s_tuser gives the frame kind (0 for an air
// conditioner notification, 1 for a heater notification; the kind on the final
// beat selects the check). Bytes are taken one per cycle with no gaps needed.
// The master channel gives one beat per frame, carrying the accepted flag and the
// whole kept device record after that frame; a rejected frame leaves the record
// as it was and reports it with the flag low.
// A finished frame is written into the queue and moves on into the output register
// when that register is empty or being read.
// Throughput: one byte per cycle; the frame checker and the record updater are
// parted by a two-frame queue, so a stalled master side only holds the slave side
// once two finished frames are waiting behind the output register.
// Reset (aresetn low, synchronous) empties the byte count, the queue and the
// output register and clears the device record to zero.

module notification_frame_decoder_unit #(
    parameter int unsigned Q_DEPTH = nfd_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tlast,   // last_byte
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] accepted, [1] power_state, [9:2] mode_code, [23:10] target_temp,
    // [37:24] current_temp, [40:38] fan_level, [41] swing_state,
    // [49:42] fault_value, [50] heater_manual, [58:51] heater_status_byte,
    // [74:59] altitude, [75] altitude_known, [79:76] zero
    output logic [79:0] m_tdata
);
    import nfd_pkg::*;

    // Classified frames travel from the checker to the updater through the queue.
    desc_t push_desc;
    desc_t q_desc;
    logic  push;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;

    nfd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_desc (push_desc),
        .q_full    (q_full)
    );

    nfd_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_desc),
        .pop       (q_pop)
    );

    // The updater owns the device record and the output register.
    nfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_desc   (q_desc),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: sv/nfd_checker.sv
`timescale 1ns / 1ps

module nfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    logic s_beat;
    logic m_beat;

    assign s_beat = s_tvalid & s_tready & (s_tlast | ~s_tlast) & (s_tuser | ~s_tuser)
                    & (s_tdata == s_tdata);
    assign m_beat = m_tvalid & m_tready;

    // No result is shown in the cycle after reset.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A taken result with altitude known is followed by no result or one with altitude still known.
    a_alt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat && m_tdata[75] |=> !m_tvalid || m_tdata[75])
        else $error("altitude known flag dropped");

    // A taken result with a nonzero fan level, while no byte is taken, is followed by no result or one in 1..5.
    a_fan_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat && m_tdata[40:38] != 3'd0 && !s_beat
        |=> !m_tvalid || (m_tdata[40:38] != 3'd0 && m_tdata[40:38] <= 3'd5))
        else $error("fan level lost or out of range");

endmodule

bind notification_frame_decoder_unit nfd_checker u_nfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: dv/notification_frame_decoder_unit_tb.sv
`timescale 1ns / 1ps

module notification_frame_decoder_unit_tb;
    import nfd_pkg::*;

    // Frame kind carried on s_tuser.
    typedef enum bit {
        FRAME_AC     = 1'b0,
        FRAME_HEATER = 1'b1
    } frame_kind_e;

    // Mirrors the decoder: it keeps its own byte buffer and device record, and
    // queues one report for every final byte that the slave side takes.
    class frame_record_tracker;
        typedef struct {
            bit   accepted;
            rec_t rec;
        } report_t;

        logic [7:0]  store [MAX_FRAME];
        int unsigned count;
        rec_t        rec;
        report_t     awaited_reports[$];
        int unsigned errors;

        function new();
            count  = 0;
            rec    = '0;
            errors = 0;
        endfunction

        function int sixteenths_of_fahr(int f);
            int n;
            n = (f - 32) * 80;
            if (n >= 0) return (n + 4) / 9;
            return -((-n + 4) / 9);
        endfunction

        function logic [2:0] clamp_fan(logic [7:0] v);
            if (v < 1) return 3'd1;
            if (v > 5) return 3'd5;
            return v[2:0];
        endfunction

        // Celsius codes lo..hi, Fahrenheit codes flo..99; anything else is ignored.
        function bit decode_temp(logic [7:0] raw, int lo, int hi, int flo, output int t);
            t = 0;
            if (raw >= lo && raw <= hi) begin
                t = int'(raw) * 16;
                return 1'b1;
            end
            if (raw >= flo && raw <= 99) begin
                t = sixteenths_of_fahr(int'(raw));
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit apply_ac_frame(int unsigned len);
            int t;
            logic [7:0] data;
            if (len != 9 || store[0] != AC_SYNC || store[1] != AC_SYNC ||
                store[7] != AC_CR || store[8] != AC_LF)
                return 1'b0;
            data = store[5];
            case (store[4])
                CMD_POWER:   rec.power = (data == POWER_ON_CODE);
                CMD_MODE:    rec.mode  = data;
                CMD_TARGET:  if (decode_temp(data, 16, 30, 60, t)) rec.target = 14'(t);
                CMD_FAN:     rec.fan   = clamp_fan(data);
                CMD_CURRENT: if (decode_temp(data, 16, 30, 60, t)) rec.current = 14'(t);
                CMD_SWING:   rec.swing = (data == SWING_ON_CODE);
                CMD_FAULT:   rec.fault = data;
                default:     return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function bit apply_heater_frame(int unsigned len);
            int t;
            logic [15:0] amb;
            if (len < 14 || len > MAX_FRAME || store[0] != HT_SYNC) return 1'b0;
            if (len == 22) begin
                rec.fault  = store[13];
                rec.manual = (store[14] == MANUAL_CODE);
                rec.fan    = clamp_fan(store[15]);
                if (decode_temp(store[16], 4, 38, 40, t)) rec.target = 14'(t);
                rec.status = store[17];
                rec.power  = (store[17] != 8'h00);
                return 1'b1;
            end
            if (len == 28) begin
                rec.fault = store[13];
                amb = {store[18], store[19]};
                if (amb <= AMB_LIMIT)
                    rec.current = 14'(sixteenths_of_fahr(int'(amb) - int'(AMB_OFFSET)));
                rec.alt       = {store[24], store[25]};
                rec.alt_known = 1'b1;
                return 1'b1;
            end
            if (len == 20 && store[12] == HT_IDLE_TAG) return 1'b1;
            if (len == 16 || len == 24) return 1'b1;
            return 1'b0;
        endfunction

        // Called for every byte beat taken by the slave side.
        function void take_byte(frame_kind_e kind, logic [7:0] b, bit last);
            int unsigned len;
            report_t r;
            if (count < MAX_FRAME) store[count] = b;
            if (count < COUNT_MAX) count++;
            if (!last) return;
            len   = count;
            count = 0;
            r.accepted = (kind == FRAME_AC) ? apply_ac_frame(len) : apply_heater_frame(len);
            r.rec      = rec;
            awaited_reports.insert(awaited_reports.size(), r);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Called for every result beat taken from the master side.
        function void check_report(logic [79:0] d);
            report_t r;
            if (awaited_reports.size() == 0) begin
                $error("result beat %h arrived with no frame outstanding", d);
                errors++;
                return;
            end
            r = awaited_reports.pop_front();
            compare_field("accepted",           r.accepted,          d[0]);
            compare_field("power_state",        r.rec.power,         d[1]);
            compare_field("mode_code",          r.rec.mode,          d[9:2]);
            compare_field("target_temp",        r.rec.target,        $signed(d[23:10]));
            compare_field("current_temp",       r.rec.current,       $signed(d[37:24]));
            compare_field("fan_level",          r.rec.fan,           d[40:38]);
            compare_field("swing_state",        r.rec.swing,         d[41]);
            compare_field("fault_value",        r.rec.fault,         d[49:42]);
            compare_field("heater_manual",      r.rec.manual,        d[50]);
            compare_field("heater_status_byte", r.rec.status,        d[58:51]);
            compare_field("altitude",           r.rec.alt,           d[74:59]);
            compare_field("altitude_known",     r.rec.alt_known,     d[75]);
            compare_field("padding",            0,                   d[79:76]);
        endfunction

        function void flag_leftovers();
            if (awaited_reports.size() != 0) begin
                $error("%0d frame results never arrived", awaited_reports.size());
                errors++;
            end
        endfunction
    endclass

    localparam int PHASE_BYTES = 330;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    frame_record_tracker tracker = new();

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned bytes_sent     = 0;
    logic [7:0]  frame_buf[$];

    logic [7:0] ac_cmds [7] = '{CMD_POWER, CMD_MODE, CMD_TARGET, CMD_FAN,
                                CMD_CURRENT, CMD_SWING, CMD_FAULT};
    // Codes at the borders of the Celsius and Fahrenheit windows of both frame kinds.
    logic [7:0] temp_edges [14] = '{8'd0, 8'd3, 8'd4, 8'd15, 8'd16, 8'd30, 8'd31,
                                    8'd38, 8'd39, 8'd40, 8'd59, 8'd60, 8'd99, 8'd100};

    notification_frame_decoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // The result side stalls at random, at the rate of the current phase.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_report(m_tdata);
    end

    // Offers one byte beat, after an optional idle gap, and waits for it to be taken.
    task automatic send_byte(frame_kind_e kind, logic [7:0] b, bit last);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 3);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        tracker.take_byte(kind, b, last);
        bytes_sent++;
    endtask

    // Only the kind on the final beat matters, so the earlier beats carry a random one.
    task automatic send_frame(frame_kind_e kind);
        for (int i = 0; i < frame_buf.size(); i++) begin
            if (i == frame_buf.size() - 1)
                send_byte(kind, frame_buf[i], 1'b1);
            else
                send_byte(frame_kind_e'($urandom_range(1)), frame_buf[i], 1'b0);
        end
    endtask

    task automatic build_ac(logic [7:0] cmd, logic [7:0] data);
        frame_buf = {AC_SYNC, AC_SYNC, 8'($urandom), 8'($urandom), cmd, data,
                     8'($urandom), AC_CR, AC_LF};
    endtask

    task automatic build_random(int len);
        frame_buf.delete();
        repeat (len) frame_buf = {frame_buf, 8'($urandom)};
    endtask

    // Heater frame of the given length with a good sync byte and random content.
    task automatic build_heater(int len);
        build_random(len);
        frame_buf[0] = HT_SYNC;
    endtask

    task automatic build_heater_short(logic [7:0] manual, logic [7:0] fan,
                                      logic [7:0] temp, logic [7:0] status);
        build_heater(22);
        frame_buf[14] = manual;
        frame_buf[15] = fan;
        frame_buf[16] = temp;
        frame_buf[17] = status;
    endtask

    task automatic build_heater_long(logic [15:0] amb, logic [15:0] alt);
        build_heater(28);
        frame_buf[18] = amb[15:8];
        frame_buf[19] = amb[7:0];
        frame_buf[24] = alt[15:8];
        frame_buf[25] = alt[7:0];
    endtask

    function automatic logic [7:0] pick_temp_code();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(0, 45));
            1:       return 8'($urandom_range(55, 105));
            2:       return 8'($urandom);
            default: return temp_edges[$urandom_range(13)];
        endcase
    endfunction

    function automatic logic [7:0] pick_ac_data(logic [7:0] cmd);
        if ($urandom_range(3) == 0) return 8'($urandom);
        case (cmd)
            CMD_POWER:                return $urandom_range(1) ? POWER_ON_CODE : 8'h00;
            CMD_TARGET, CMD_CURRENT: return pick_temp_code();
            CMD_FAN:                 return 8'($urandom_range(0, 7));
            CMD_SWING:               return $urandom_range(1) ? SWING_ON_CODE : 8'h00;
            default:                 return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_ambient();
        case ($urandom_range(5))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 80));
            2:       return $urandom_range(1) ? AMB_LIMIT : AMB_LIMIT + 16'd1;
            default: return 16'($urandom_range(0, 700));
        endcase
    endfunction

    // One random frame: mostly well-formed frames with random content, the rest
    // broken frames and noise.
    task automatic random_frame();
        logic [7:0] cmd;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            cmd = ($urandom_range(9) == 0) ? 8'($urandom) : ac_cmds[$urandom_range(6)];
            build_ac(cmd, pick_ac_data(cmd));
            send_frame(FRAME_AC);
        end else if (pick < 72) begin
            case ($urandom_range(5))
                0, 1: build_heater_short($urandom_range(1) ? MANUAL_CODE : 8'($urandom),
                                         $urandom_range(1) ? 8'($urandom_range(0, 7))
                                                           : 8'($urandom),
                                         pick_temp_code(),
                                         $urandom_range(3) == 0 ? 8'h00 : 8'($urandom));
                2, 3: build_heater_long(pick_ambient(), 16'($urandom));
                4: begin
                    build_heater(20);
                    if ($urandom_range(3) != 0) frame_buf[12] = HT_IDLE_TAG;
                end
                default: build_heater($urandom_range(1) ? 16 : 24);
            endcase
            send_frame(FRAME_HEATER);
        end else if (pick < 82) begin
            // Well-formed frame, mostly with one framing fault, sent under either kind.
            cmd = ac_cmds[$urandom_range(6)];
            build_ac(cmd, pick_ac_data(cmd));
            case ($urandom_range(4))
                0: frame_buf[$urandom_range(1)] = 8'($urandom);
                1: frame_buf[7 + $urandom_range(1)] = 8'($urandom);
                2: frame_buf = {frame_buf, 8'($urandom)};
                3: frame_buf.delete($urandom_range(8));
                default: ;
            endcase
            send_frame(frame_kind_e'($urandom_range(1)));
        end else if (pick < 90) begin
            build_heater($urandom_range(12, 30));
            if ($urandom_range(1)) frame_buf[0] = 8'($urandom);
            send_frame(frame_kind_e'($urandom_range(1)));
        end else begin
            build_random(($urandom_range(9) == 0) ? $urandom_range(33, 70)
                                                  : $urandom_range(1, 30));
            send_frame(frame_kind_e'($urandom_range(1)));
        end
    endtask

    initial begin
        int unsigned phase_end;
        int          waited;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed frames: every command, the temperature windows, fan clamping,
        // all heater lengths and the overlong frame with a saturated count.
        build_ac(CMD_POWER, POWER_ON_CODE);  send_frame(FRAME_AC);
        build_ac(CMD_MODE, 8'hFF);           send_frame(FRAME_AC);
        build_ac(CMD_TARGET, 8'd16);         send_frame(FRAME_AC);
        build_ac(CMD_TARGET, 8'd99);         send_frame(FRAME_AC);
        build_ac(CMD_TARGET, 8'd15);         send_frame(FRAME_AC);
        build_ac(CMD_CURRENT, 8'd60);        send_frame(FRAME_AC);
        build_ac(CMD_CURRENT, 8'd30);        send_frame(FRAME_AC);
        build_ac(CMD_FAN, 8'h00);            send_frame(FRAME_AC);
        build_ac(CMD_FAN, 8'hFF);            send_frame(FRAME_AC);
        build_ac(CMD_SWING, SWING_ON_CODE);  send_frame(FRAME_AC);
        build_ac(CMD_FAULT, 8'hFF);          send_frame(FRAME_AC);
        build_ac(CMD_POWER, 8'h00);          send_frame(FRAME_AC);
        build_ac(8'h05, 8'h00);              send_frame(FRAME_AC);
        build_ac(CMD_MODE, 8'h11);
        frame_buf[8] = 8'h00;                send_frame(FRAME_AC);
        build_heater_short(MANUAL_CODE, 8'h00, 8'd4, 8'h00);  send_frame(FRAME_HEATER);
        build_heater_short(8'h00, 8'd9, 8'd99, 8'h80);        send_frame(FRAME_HEATER);
        build_heater_long(16'd0, 16'hFFFF);                   send_frame(FRAME_HEATER);
        build_heater_long(AMB_LIMIT + 16'd1, 16'h0000);       send_frame(FRAME_HEATER);
        build_heater_long(AMB_LIMIT, 16'h1234);               send_frame(FRAME_HEATER);
        build_heater(20);
        frame_buf[12] = HT_IDLE_TAG;                          send_frame(FRAME_HEATER);
        build_heater(16);                                     send_frame(FRAME_HEATER);
        build_heater(24);                                     send_frame(FRAME_HEATER);
        build_heater(14);                                     send_frame(FRAME_HEATER);
        build_heater(70);                                     send_frame(FRAME_HEATER);
        build_random(1);                                      send_frame(FRAME_AC);

        // Random frames in four idling phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) random_frame();
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;

        waited = 0;
        while (tracker.awaited_reports.size() != 0 && waited < 4000) begin
            @(posedge aclk);
            waited++;
        end
        tracker.flag_leftovers();
        repeat (10) @(posedge aclk);

        if (tracker.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
